// ===== rtl/async_hdlc_frame_encoder_core_assert.svh =====
// assertion macros shared by the hdlc frame encoder rtl
// no dependencies; included inside module bodies
`ifndef ASYNC_HDLC_FRAME_ENCODER_CORE_ASSERT_SVH
`define ASYNC_HDLC_FRAME_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AHFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define AHFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ahfe_pkg.sv =====
// types, constants and the crc step for the hdlc frame encoder
// no dependencies
`timescale 1ns / 1ps

package ahfe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam int          QDEPTH    = 4;

  // one queued job: a payload byte plus what the back end needs to frame it
  typedef struct packed {
    logic [7:0]  data;
    logic        open;
    logic        last;
    logic [15:0] fcs;
  } ahfe_job_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_OPEN,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_CLOSE
  } ahfe_phase_e;

  // reflected crc-16/x.25 over one byte, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/ahfe_if.sv =====
// valid/ready channel interfaces for the hdlc frame encoder
// no dependencies
`timescale 1ns / 1ps

interface ahfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

interface ahfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_end,
                output ready);
endinterface

// ===== rtl/ahfe_front.sv =====
// front end: accepts payload beats, runs the crc and frame state, builds jobs
// depends on ahfe_pkg
`timescale 1ns / 1ps

module ahfe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_data_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ahfe_pkg::ahfe_job_t q_job_o
);
  import ahfe_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic        open_q, open_d;
  logic [15:0] crc_next;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign crc_next   = crc_byte(crc_q, in_data_i);

  always_comb begin
    q_job_o.data = in_data_i;
    q_job_o.open = !open_q;
    q_job_o.last = in_last_i;
    q_job_o.fcs  = ~crc_next;
  end

  always_comb begin
    crc_d  = crc_q;
    open_d = open_q;
    if (q_push_o) begin
      if (in_last_i) begin
        crc_d  = CRC_SEED;
        open_d = 1'b0;
      end else begin
        crc_d  = crc_next;
        open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_SEED;
      open_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      open_q <= open_d;
    end
  end

endmodule

// ===== rtl/ahfe_fifo.sv =====
// short job queue between the front and back ends
// depends on ahfe_pkg
`timescale 1ns / 1ps

module ahfe_fifo #(
  parameter int DEPTH = ahfe_pkg::QDEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ahfe_pkg::ahfe_job_t job_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output ahfe_pkg::ahfe_job_t job_o
);
  import ahfe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ahfe_job_t     mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `include "async_hdlc_frame_encoder_core_assert.svh"

  `AHFE_ASSERT_SAME(a_no_push_full, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `AHFE_ASSERT_SAME(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `AHFE_ASSERT_NEXT(a_cnt_track, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

// ===== rtl/ahfe_back.sv =====
// back end: expands each job into its escaped data and any flag and fcs beats
// depends on ahfe_pkg
`timescale 1ns / 1ps

module ahfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  ahfe_pkg::ahfe_job_t q_job_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_run_last_o,
  output logic                out_frame_end_o
);
  import ahfe_pkg::*;

  ahfe_phase_e phase_q, phase_d, cur_phase, next_phase;
  logic        esc_q, esc_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        run_last_q, run_last_d;
  logic        frame_end_q, frame_end_d;
  logic [7:0]  cur_byte;
  logic        needs_esc, byte_done, go, finish;

  assign go = !q_empty_i && (!valid_q || out_ready_i);

  always_comb begin
    cur_phase = phase_q;
    if (phase_q == PH_START) begin
      cur_phase = q_job_i.open ? PH_OPEN : PH_DATA;
    end

    case (cur_phase)
      PH_DATA:   cur_byte = q_job_i.data;
      PH_FCS_LO: cur_byte = q_job_i.fcs[7:0];
      PH_FCS_HI: cur_byte = q_job_i.fcs[15:8];
      default:   cur_byte = FLAG_BYTE;
    endcase

    needs_esc = (cur_phase inside {PH_DATA, PH_FCS_LO, PH_FCS_HI})
                && (cur_byte inside {FLAG_BYTE, ESC_BYTE});
    byte_done = !needs_esc || esc_q;

    finish = 1'b0;
    case (cur_phase)
      PH_OPEN:   next_phase = PH_DATA;
      PH_DATA: begin
        next_phase = q_job_i.last ? PH_FCS_LO : PH_START;
        finish     = !q_job_i.last;
      end
      PH_FCS_LO: next_phase = PH_FCS_HI;
      PH_FCS_HI: next_phase = PH_CLOSE;
      PH_CLOSE: begin
        next_phase = PH_START;
        finish     = 1'b1;
      end
      default:   next_phase = PH_START;
    endcase
    finish = finish && byte_done;

    phase_d     = phase_q;
    esc_d       = esc_q;
    valid_d     = valid_q && !out_ready_i;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    frame_end_d = frame_end_q;
    q_pop_o     = 1'b0;

    if (go) begin
      valid_d     = 1'b1;
      run_last_d  = finish;
      frame_end_d = (cur_phase == PH_CLOSE);
      q_pop_o     = finish;
      if (!byte_done) begin
        // first half of an escape pair, stay on this byte
        byte_d  = ESC_BYTE;
        esc_d   = 1'b1;
        phase_d = cur_phase;
      end else begin
        byte_d  = esc_q ? (cur_byte ^ ESC_XOR) : cur_byte;
        esc_d   = 1'b0;
        phase_d = next_phase;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      esc_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    run_last_q  <= run_last_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign out_run_last_o  = run_last_q;
  assign out_frame_end_o = frame_end_q;

  `include "async_hdlc_frame_encoder_core_assert.svh"

  `AHFE_ASSERT_SAME(a_end_is_flag, clk_i, rst_ni, valid_q && frame_end_q, byte_q == FLAG_BYTE && run_last_q, "closing beat is not a last flag")
  `AHFE_ASSERT_SAME(a_esc_holds_job, clk_i, rst_ni, esc_q, !q_empty_i && phase_q != PH_START, "escape pending without a job")
  `AHFE_ASSERT_NEXT(a_esc_pair, clk_i, rst_ni, go && !byte_done, valid_q && byte_q == ESC_BYTE && !run_last_q, "escape beat missing")

endmodule

// ===== rtl/async_hdlc_frame_encoder_core.sv =====
// Async HDLC-style frame encoder, transmit direction.
// in_i carries one payload byte per beat with frame_last marking the final
// byte of a frame. out_o carries the line stream one byte per beat: an opening
// 0x7E before the first byte of a frame, each byte escaped with 0x7D where it
// is 0x7E or 0x7D, and after the last byte the complemented CRC-16/X.25 low
// byte first (escaped) and a closing 0x7E flagged by frame_end. run_last marks
// the final output beat that an input beat causes.
// An accepted input beat is queued as a job, and the back end registers its
// first output beat from the queue head. It emits one output beat per cycle
// with a job queued and the receiver ready; an input beat gives 1 to 8 beats.
// Input beats are taken one per cycle while the job queue has room.
// The job queue (QDEPTH entries) decouples the input from the output: when the
// receiver stalls, the output register holds, the queue fills and in_i.ready
// drops once it is full. Reset clears the crc to 0xFFFF, closes any frame,
// empties the queue and drops out valid.
// depends on ahfe_pkg, ahfe_if, ahfe_front, ahfe_fifo, ahfe_back
`timescale 1ns / 1ps

module async_hdlc_frame_encoder_core #(
  parameter int QDEPTH = ahfe_pkg::QDEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  ahfe_in_if.sink    in_i,
  ahfe_out_if.source out_o
);
  import ahfe_pkg::*;

  ahfe_job_t push_job, head_job;
  logic      q_full, q_empty, q_push, q_pop;

  ahfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data_byte),
    .in_last_i  (in_i.frame_last),
    .in_ready_o (in_i.ready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  ahfe_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (head_job)
  );

  ahfe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_job_i         (head_job),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .out_run_last_o  (out_o.run_last),
    .out_frame_end_o (out_o.frame_end)
  );

endmodule

// ===== tb/tb_async_hdlc_frame_encoder_core.sv =====
// testbench for async_hdlc_frame_encoder_core: directed and random payload frames with
// random gaps on both channels, line stream checked against an in-bench frame encoder
// depends on ahfe_pkg, ahfe_if and the rtl of the encoder core
`timescale 1ns / 1ps

module tb_async_hdlc_frame_encoder_core;
  import ahfe_pkg::FLAG_BYTE;
  import ahfe_pkg::ESC_BYTE;
  import ahfe_pkg::ESC_XOR;
  import ahfe_pkg::CRC_POLY;
  import ahfe_pkg::CRC_SEED;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 450;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } line_beat_t;

  logic clk_i;
  logic rst_ni;

  ahfe_in_if  in_if ();
  ahfe_out_if out_if ();

  async_hdlc_frame_encoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // encoder state mirrored in the bench
  logic [15:0] fcs_accum;
  logic        frame_active;

  line_beat_t expected_line_beats[$];
  line_beat_t item_beats[8];
  int         item_beat_cnt;

  int  mismatches;
  int  cycle_count;
  int  sink_stall_left;
  bit  steady;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // bit-serial reflected crc, lsb of the data byte first
  function automatic logic [15:0] crc_x25_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = {1'b0, r[15:1]};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic bit needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic void add_beat(input logic [7:0] b, input logic is_close);
    item_beats[item_beat_cnt] = '{out_byte: b, run_last: 1'b0, frame_end: is_close};
    item_beat_cnt++;
  endfunction

  function automatic void add_stuffed(input logic [7:0] b);
    if (needs_escape(b)) begin
      add_beat(ESC_BYTE, 1'b0);
      add_beat(b ^ ESC_XOR, 1'b0);
    end else begin
      add_beat(b, 1'b0);
    end
  endfunction

  // line beats produced by one accepted payload byte
  function automatic void predict_line_beats(input logic [7:0] b, input logic last);
    logic [15:0] fcs;
    item_beat_cnt = 0;
    if (!frame_active) begin
      add_beat(FLAG_BYTE, 1'b0);
      frame_active = 1'b1;
    end
    add_stuffed(b);
    fcs_accum = crc_x25_step(fcs_accum, b);
    if (last) begin
      fcs = ~fcs_accum;
      add_stuffed(fcs[7:0]);
      add_stuffed(fcs[15:8]);
      add_beat(FLAG_BYTE, 1'b1);
      fcs_accum    = CRC_SEED;
      frame_active = 1'b0;
    end
    item_beats[item_beat_cnt-1].run_last = 1'b1;
    for (int k = 0; k < item_beat_cnt; k++) expected_line_beats.push_back(item_beats[k]);
  endfunction

  // called right after a rising edge; returns right after the edge that takes the beat
  task automatic send_payload_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.frame_last <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_line_beats(b, last);
  endtask

  // receiver with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready    <= 1'b0;
      sink_stall_left <= 0;
    end else if (sink_stall_left > 0) begin
      out_if.ready    <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 20) sink_stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    line_beat_t exp_b;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_line_beats.size() == 0) begin
        $display("%0t: unexpected beat, got byte %h run_last %b frame_end %b", $time,
                 out_if.out_byte, out_if.run_last, out_if.frame_end);
        mismatches++;
      end else begin
        exp_b = expected_line_beats.pop_front();
        if (out_if.out_byte !== exp_b.out_byte) begin
          $display("%0t: out_byte mismatch, expected %h actual %h", $time,
                   exp_b.out_byte, out_if.out_byte);
          mismatches++;
        end
        if (out_if.run_last !== exp_b.run_last) begin
          $display("%0t: run_last mismatch, expected %b actual %b", $time,
                   exp_b.run_last, out_if.run_last);
          mismatches++;
        end
        if (out_if.frame_end !== exp_b.frame_end) begin
          $display("%0t: frame_end mismatch, expected %b actual %b", $time,
                   exp_b.frame_end, out_if.frame_end);
          mismatches++;
        end
      end
    end
  end

  task automatic test_single_byte_frames();
    send_payload_byte(8'h00, 1'b1);
    send_payload_byte(8'hFF, 1'b1);
    send_payload_byte(FLAG_BYTE, 1'b1);
    send_payload_byte(ESC_BYTE, 1'b1);
  endtask

  task automatic test_escapes_in_frame();
    send_payload_byte(FLAG_BYTE, 1'b0);
    send_payload_byte(ESC_BYTE, 1'b0);
    send_payload_byte(8'h00, 1'b0);
    send_payload_byte(8'hFF, 1'b0);
    send_payload_byte(FLAG_BYTE ^ ESC_XOR, 1'b0);
    send_payload_byte(ESC_XOR, 1'b1);
  endtask

  // two-byte frames whose fcs needs escaping in the low byte, the high byte, and both
  task automatic test_escaped_fcs();
    logic [15:0] fcs;
    bit          found[3];
    logic [7:0]  pick0[3];
    logic [7:0]  pick1[3];
    int          sel;
    for (int a = 0; a < 256; a++) begin
      for (int c = 0; c < 256; c++) begin
        fcs = ~crc_x25_step(crc_x25_step(CRC_SEED, a[7:0]), c[7:0]);
        if (needs_escape(fcs[7:0]) && needs_escape(fcs[15:8])) sel = 2;
        else if (needs_escape(fcs[7:0])) sel = 0;
        else if (needs_escape(fcs[15:8])) sel = 1;
        else sel = -1;
        if (sel >= 0 && !found[sel]) begin
          found[sel] = 1'b1;
          pick0[sel] = a[7:0];
          pick1[sel] = c[7:0];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (found[k]) begin
        send_payload_byte(pick0[k], 1'b0);
        send_payload_byte(pick1[k], 1'b1);
      end
    end
  endtask

  task automatic test_random_frames();
    int         sent;
    int         len;
    int         r;
    logic [7:0] b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 24);
      else len = $urandom_range(25, 60);
      // some frames run back to back with no idling at all
      steady = ($urandom_range(0, 99) < 15);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 11);
        if (r == 0) b = FLAG_BYTE;
        else if (r == 1) b = ESC_BYTE;
        else b = $urandom_range(0, 255);
        send_payload_byte(b, k == len - 1);
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    steady       = 1'b0;
    fcs_accum    = CRC_SEED;
    frame_active = 1'b0;
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= 8'h00;
    in_if.frame_last <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_frames();
    test_escapes_in_frame();
    test_escaped_fcs();
    test_random_frames();
    in_if.valid <= 1'b0;

    while (expected_line_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
